// File: rtl/pdbm_pkg.sv
// Shared types, constants and the level threshold table for the peak dB level meter.
`default_nettype none

package pdbm_pkg;

  localparam int DATA_W      = 16;               // sample and peak width
  localparam int LVL_W       = 7;                // meter level width
  localparam int LEVEL_STEPS = 100;              // top of the level scale
  localparam int LVL_CAP     = (LEVEL_STEPS > 127) ? 127 : LEVEL_STEPS;
  localparam int NUM_LVL     = 1 << LVL_W;
  localparam int THR_W       = DATA_W + 1;       // thresholds reach full scale + 1
  localparam int SRCH_STAGES = LVL_W;            // one level bit per stage

  localparam int MID_DEPTH   = 4;
  localparam int MID_AW      = 2;
  localparam int OUT_DEPTH   = 8;                // covers the search pipeline + 1
  localparam int OUT_AW      = 3;

  localparam logic [LVL_W-1:0] RELEASE_RST = 7'd6;

  localparam longint LOG2_FULL_Q16  = 983037;    // log2(32767), Q16
  localparam longint DB_PER_OCT_Q16 = 394566;    // 20*log10(2), Q16
  localparam longint DB_BOTTOM      = 52;
  localparam longint SPAN_DB        = 44;
  localparam int     FULL_SCALE     = 32768;     // largest possible peak
  localparam int     NO_THR         = FULL_SCALE + 1;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef logic [NUM_LVL-1:0][THR_W-1:0] thr_tab_t;

  // log2 in Q16 by repeated squaring of the normalized mantissa
  function automatic logic [31:0] log2_q16(input logic [31:0] v);
    logic [31:0] e;
    logic [63:0] m;
    logic [31:0] frac;
    e    = '0;
    frac = '0;
    for (int i = 0; i < 31; i++) begin
      if ((v >> (i + 1)) != 0) e = 32'(i + 1);
    end
    m = 64'(v) << (30 - e);
    for (int i = 0; i < 16; i++) begin
      m    = (m * m) >> 30;
      frac = frac << 1;
      if (m >= 64'h8000_0000) begin
        m    = m >> 1;
        frac = frac | 32'd1;
      end
    end
    return (e << 16) + frac;
  endfunction

  function automatic int chunk_lvl(input int peak);
    longint d;
    longint num;
    longint lvl;
    if (peak == 0) return 0;
    d   = longint'(log2_q16(32'(peak))) - LOG2_FULL_Q16;
    num = d * DB_PER_OCT_Q16 + (DB_BOTTOM << 32);
    if (num < 0) return 0;
    lvl = (num * LEVEL_STEPS) / (SPAN_DB << 32);
    if (lvl > LVL_CAP) lvl = LVL_CAP;
    return int'(lvl);
  endfunction

  // Smallest peak reaching each level; the level is monotonic in the peak.
  function automatic thr_tab_t build_thr();
    thr_tab_t t;
    int lo;
    int hi;
    int mid;
    int top;
    top = chunk_lvl(FULL_SCALE);
    for (int k = 0; k < NUM_LVL; k++) begin
      if (k == 0) begin
        t[k] = '0;
      end else if (k > top) begin
        t[k] = THR_W'(NO_THR);
      end else begin
        lo = 1;
        hi = FULL_SCALE;
        for (int j = 0; j < 17; j++) begin
          if (lo < hi) begin
            mid = (lo + hi) / 2;
            if (chunk_lvl(mid) >= k) hi = mid;
            else lo = mid + 1;
          end
        end
        t[k] = THR_W'(lo);
      end
    end
    return t;
  endfunction

  localparam thr_tab_t THR_TAB = build_thr();

endpackage

`default_nettype wire

// File: rtl/pdbm_front.sv
// Front end: sample magnitude, running chunk peak, hands finished peaks to the queue.
`default_nettype none

module pdbm_front (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_push,
  output logic                                 in_full,
  input  wire  signed [pdbm_pkg::DATA_W-1:0]   in_sample,
  input  wire                                  in_is_last,
  input  pdbm_pkg::q_stat_t                    mid_stat,
  output logic                                 mid_push,
  output logic        [pdbm_pkg::DATA_W-1:0]   mid_wdata
);

  logic [pdbm_pkg::DATA_W-1:0] run_peak_r, run_peak_nxt;
  logic [pdbm_pkg::DATA_W-1:0] mag;
  logic [pdbm_pkg::DATA_W-1:0] peak_now;
  logic                        acc;

  // -32768 wraps to 0x8000, read as unsigned 32768
  assign mag      = in_sample[pdbm_pkg::DATA_W-1] ? (~in_sample + 1'b1) : in_sample;
  assign peak_now = (mag > run_peak_r) ? mag : run_peak_r;
  assign in_full  = mid_stat.full;
  assign acc      = in_push && !mid_stat.full;

  assign mid_push  = acc && in_is_last;
  assign mid_wdata = peak_now;

  always_comb begin
    run_peak_nxt = run_peak_r;
    if (acc) begin
      run_peak_nxt = in_is_last ? '0 : peak_now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_peak_r <= '0;
    end else begin
      run_peak_r <= run_peak_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/pdbm_queue.sv
// Small register queue carrying chunk peaks from the front end to the back end.
`default_nettype none

module pdbm_queue (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                push,
  input  wire  [pdbm_pkg::DATA_W-1:0]        wdata,
  input  wire                                pop,
  output logic [pdbm_pkg::DATA_W-1:0]        rdata,
  output pdbm_pkg::q_stat_t                  stat
);

  logic [pdbm_pkg::DATA_W-1:0] mem_r [pdbm_pkg::MID_DEPTH];
  logic [pdbm_pkg::MID_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [pdbm_pkg::MID_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [pdbm_pkg::MID_AW:0]   cnt_r, cnt_nxt;
  logic                        do_push;
  logic                        do_pop;

  assign stat.full  = (cnt_r == (pdbm_pkg::MID_AW+1)'(pdbm_pkg::MID_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (pdbm_pkg::MID_AW+1)'(do_push) - (pdbm_pkg::MID_AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

// File: rtl/pdbm_back.sv
// Back end: pipelined level search, meter attack/release and the result queue.
`default_nettype none

module pdbm_back (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                cfg_wr_en,
  input  wire  [pdbm_pkg::LVL_W-1:0]         cfg_wr_data,
  input  pdbm_pkg::q_stat_t                  mid_stat,
  input  wire  [pdbm_pkg::DATA_W-1:0]        mid_rdata,
  output logic                               mid_pop,
  output logic                               out_empty,
  input  wire                                out_pop,
  output logic [pdbm_pkg::LVL_W-1:0]         out_meter_level,
  output logic [pdbm_pkg::DATA_W-1:0]        out_chunk_peak
);

  localparam int NS = pdbm_pkg::SRCH_STAGES;
  localparam int OW = pdbm_pkg::LVL_W + pdbm_pkg::DATA_W;

  // search pipeline
  logic                          st_vld_r  [NS];
  logic [pdbm_pkg::DATA_W-1:0]   st_peak_r [NS];
  logic [pdbm_pkg::LVL_W-1:0]    st_acc_r  [NS];
  logic                          src_vld   [NS];
  logic [pdbm_pkg::DATA_W-1:0]   src_peak  [NS];
  logic [pdbm_pkg::LVL_W-1:0]    src_acc   [NS];
  logic [pdbm_pkg::LVL_W-1:0]    cand      [NS];
  logic [pdbm_pkg::LVL_W-1:0]    acc_nxt   [NS];

  logic [pdbm_pkg::LVL_W-1:0]    rel_r;
  logic [pdbm_pkg::LVL_W-1:0]    level_r, level_nxt;
  logic [pdbm_pkg::LVL_W-1:0]    lvl_fin;

  // result queue with slot reservation
  logic [OW-1:0]                 oq_mem_r [pdbm_pkg::OUT_DEPTH];
  logic [pdbm_pkg::OUT_AW-1:0]   oq_wr_r, oq_rd_r;
  logic [pdbm_pkg::OUT_AW:0]     oq_cnt_r, oq_cnt_nxt;
  logic [pdbm_pkg::OUT_AW:0]     rsv_r, rsv_nxt;
  logic                          oq_push;
  logic                          oq_pop;
  logic                          issue;

  assign oq_pop  = out_pop && !out_empty;
  assign issue   = !mid_stat.empty &&
                   (rsv_r != (pdbm_pkg::OUT_AW+1)'(pdbm_pkg::OUT_DEPTH));
  assign mid_pop = issue;

  // each stage settles one level bit, MSB first
  for (genvar g = 0; g < NS; g++) begin : g_srch
    if (g == 0) begin : g_head
      assign src_vld[g]  = issue;
      assign src_peak[g] = mid_rdata;
      assign src_acc[g]  = '0;
    end else begin : g_body
      assign src_vld[g]  = st_vld_r[g-1];
      assign src_peak[g] = st_peak_r[g-1];
      assign src_acc[g]  = st_acc_r[g-1];
    end
    assign cand[g]    = src_acc[g] | (pdbm_pkg::LVL_W'(1) << (NS - 1 - g));
    assign acc_nxt[g] = (pdbm_pkg::THR_TAB[cand[g]] <= {1'b0, src_peak[g]}) ?
                        cand[g] : src_acc[g];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_vld_r[g] <= 1'b0;
      end else begin
        st_vld_r[g] <= src_vld[g];
      end
    end

    always_ff @(posedge clk) begin
      st_peak_r[g] <= src_peak[g];
      st_acc_r[g]  <= acc_nxt[g];
    end
  end

  // instant attack, release by the configurable release step, floored at zero
  assign lvl_fin = st_acc_r[NS-1];
  assign oq_push = st_vld_r[NS-1];

  always_comb begin
    if (lvl_fin > level_r) begin
      level_nxt = lvl_fin;
    end else if (level_r > rel_r) begin
      level_nxt = level_r - rel_r;
    end else begin
      level_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rel_r   <= pdbm_pkg::RELEASE_RST;
      level_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        rel_r <= cfg_wr_data;
      end
      if (oq_push) begin
        level_r <= level_nxt;
      end
    end
  end

  always_comb begin
    oq_cnt_nxt = oq_cnt_r + (pdbm_pkg::OUT_AW+1)'(oq_push) - (pdbm_pkg::OUT_AW+1)'(oq_pop);
    rsv_nxt    = rsv_r + (pdbm_pkg::OUT_AW+1)'(issue) - (pdbm_pkg::OUT_AW+1)'(oq_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
      rsv_r    <= '0;
    end else begin
      if (oq_push) oq_wr_r <= oq_wr_r + 1'b1;
      if (oq_pop)  oq_rd_r <= oq_rd_r + 1'b1;
      oq_cnt_r <= oq_cnt_nxt;
      rsv_r    <= rsv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_mem_r[oq_wr_r] <= {level_nxt, st_peak_r[NS-1]};
    end
  end

  assign out_empty       = (oq_cnt_r == '0);
  assign out_meter_level = oq_mem_r[oq_rd_r][OW-1 -: pdbm_pkg::LVL_W];
  assign out_chunk_peak  = oq_mem_r[oq_rd_r][pdbm_pkg::DATA_W-1:0];

endmodule

`default_nettype wire

// File: rtl/peak_db_level_meter.sv
// Top level of the peak dB level meter: front end, chunk queue and back end.
// Throughput: one sample word per cycle while in_full is low; chunk results can
//   also leave one per cycle. A last-of-chunk word goes through the queue hop,
//   seven search stages and one meter/result-queue stage to the result side.
// in_full rises only when the four-entry chunk queue fills, i.e. when results back up.
// Reset (rst_n low, synchronous): queues empty, chunk peak and meter at 0,
//   release_step back to 6.
`default_nettype none

module peak_db_level_meter (
  input  wire                                clk,
  input  wire                                rst_n,
  // sample words
  input  wire                                in_push,
  output logic                               in_full,
  input  wire  signed [pdbm_pkg::DATA_W-1:0] in_sample,
  input  wire                                in_is_last,
  // result words
  output logic                               out_empty,
  input  wire                                out_pop,
  output logic [pdbm_pkg::LVL_W-1:0]         out_meter_level,
  output logic [pdbm_pkg::DATA_W-1:0]        out_chunk_peak,
  // release_step register
  input  wire                                cfg_wr_en,
  input  wire  [pdbm_pkg::LVL_W-1:0]         cfg_wr_data
);

  pdbm_pkg::q_stat_t           mid_stat;
  logic                        mid_push;
  logic                        mid_pop;
  logic [pdbm_pkg::DATA_W-1:0] mid_wdata;
  logic [pdbm_pkg::DATA_W-1:0] mid_rdata;

  // Front end: |sample| and running max; on the last word of a chunk the
  // finished peak goes into the chunk queue and the running max clears.
  pdbm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_sample  (in_sample),
    .in_is_last (in_is_last),
    .mid_stat   (mid_stat),
    .mid_push   (mid_push),
    .mid_wdata  (mid_wdata)
  );

  // Chunk queue decouples sample intake from the level search.
  pdbm_queue u_mid (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .wdata (mid_wdata),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .stat  (mid_stat)
  );

  // Back end: the dB level is found by a binary search of a precomputed
  // threshold table (smallest peak per level), one level bit per stage.
  // A chunk is only issued when a result queue slot is reserved for it,
  // so the search pipeline never has to stall.
  pdbm_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .mid_stat        (mid_stat),
    .mid_rdata       (mid_rdata),
    .mid_pop         (mid_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_meter_level (out_meter_level),
    .out_chunk_peak  (out_chunk_peak)
  );

endmodule

`default_nettype wire

// File: rtl/pdbm_checker.sv
// Port-level checks for the peak dB level meter, bound to the top level.
`default_nettype none

module pdbm_checker (
  input wire                                clk,
  input wire                                rst_n,
  input wire                                in_full,
  input wire                                out_empty,
  input wire                                out_pop,
  input wire        [pdbm_pkg::LVL_W-1:0]   out_meter_level,
  input wire        [pdbm_pkg::DATA_W-1:0]  out_chunk_peak
);

  // reset leaves no result word behind and the input open
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> (out_empty && !in_full))
    else $error("queues not empty after reset");

  // meter never exceeds the scale
  a_lvl_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_meter_level <= pdbm_pkg::LVL_W'(pdbm_pkg::LVL_CAP))
    else $error("meter level above scale");

  // peak never exceeds full-scale magnitude
  a_peak_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_chunk_peak <= 16'h8000)
    else $error("chunk peak above 32768");

  // a waiting result word holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_meter_level) && $stable(out_chunk_peak)))
    else $error("result word changed before pop");

endmodule

bind peak_db_level_meter pdbm_checker u_pdbm_checker (.*);

`default_nettype wire
